// ===== rtl/periodic_task_dispatcher_macros.svh =====
// Assertion macros for the periodic task dispatcher checks.
// Each macro expects clk and rst in the enclosing scope.
`ifndef PERIODIC_TASK_DISPATCHER_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PTD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("periodic task dispatcher check failed");

// Consequent must hold in the cycle after the antecedent
`define PTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("periodic task dispatcher check failed");

`endif

// ===== rtl/ptd_pkg.sv =====
package ptd_pkg;

  // Table size and derived widths
  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Field widths
  localparam int TIME_W       = 32;
  localparam int MASK_W       = 8;
  localparam int STATUS_W     = 2;
  localparam int TASK_INDEX_W = 3;

  // Results kept per tick
  localparam int RESULT_LIMIT = 8;
  localparam int RES_IDX_W    = $clog2(RESULT_LIMIT);
  localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

  // Action codes
  localparam logic ACTION_TICK = 1'b0;
  localparam logic ACTION_ADD  = 1'b1;

  // Task kinds
  localparam logic KIND_FUNCTION = 1'b0;
  localparam logic KIND_WORKER   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_FIRED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_t;

  // Tick token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] now;
  } tick_token_t;

  // New task written into one cell
  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] start_at;
    logic              pending;
  } task_write_t;

endpackage

// ===== rtl/ptd_in_if.sv =====
interface ptd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [ptd_pkg::TIME_W-1:0]    now_ms;
  logic [ptd_pkg::MASK_W-1:0]    enable_mask;
  logic                          task_kind;
  logic [ptd_pkg::TIME_W-1:0]    period_ms;
  logic [ptd_pkg::TIME_W-1:0]    start_delay_ms;

  modport source (
    output valid, action, now_ms, enable_mask, task_kind, period_ms, start_delay_ms,
    input  ready
  );

  modport sink (
    input  valid, action, now_ms, enable_mask, task_kind, period_ms, start_delay_ms,
    output ready
  );
endinterface

// ===== rtl/ptd_out_if.sv =====
interface ptd_out_if;
  logic                              valid;
  logic                              ready;
  logic [ptd_pkg::STATUS_W-1:0]      status;
  logic [ptd_pkg::TASK_INDEX_W-1:0]  task_index;
  logic                              last;

  modport source (
    output valid, status, task_index, last,
    input  ready
  );

  modport sink (
    input  valid, status, task_index, last,
    output ready
  );
endinterface

// ===== rtl/ptd_cell.sv =====
module ptd_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  ptd_pkg::tick_token_t  token_in,
  output ptd_pkg::tick_token_t  token_out,
  input  logic                  active,
  input  logic                  enable,
  input  logic                  wr_en,
  input  ptd_pkg::task_write_t  wr_data,
  output logic                  fire
);

  ptd_pkg::tick_token_t              token;
  logic                              kind;
  logic [ptd_pkg::TIME_W-1:0]        interval;
  logic [ptd_pkg::TIME_W-1:0]        last_run;
  logic [ptd_pkg::TIME_W-1:0]        start_at;
  logic                              pending;
  logic [ptd_pkg::TIME_W-1:0]        elapsed;
  logic                              due;
  logic                              candidate;

  // Pass the tick token one cell down every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      token.valid <= 1'b0;
    end else begin
      token.valid <= token_in.valid;
    end
    token.now <= token_in.now;
  end

  assign token_out = token;

  // Decide whether this slot fires on the visiting tick
  always_comb begin
    elapsed   = token.now - last_run;
    due       = (elapsed >= interval);
    candidate = 1'b0;
    if (kind == ptd_pkg::KIND_FUNCTION) begin
      candidate = due;
    end else if (enable) begin
      candidate = pending ? (token.now >= start_at) : due;
    end
  end

  assign fire = token.valid && active && candidate;

  // Store a new task, or record a firing
  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind     <= wr_data.kind;
      interval <= wr_data.interval;
      start_at <= wr_data.start_at;
      pending  <= wr_data.pending;
      last_run <= '0;
    end else if (fire) begin
      last_run <= token.now;
      if (kind == ptd_pkg::KIND_WORKER) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/periodic_task_dispatcher.sv =====
// Periodic task dispatcher: holds up to ptd_pkg::MAX_TASKS periodic tasks in a
// row of cells, one task per cell. An add transaction stores a task in the
// next free cell and answers in the next cycle with "added" and its index, or
// "table full". A tick transaction sends a token carrying the current time
// down the row from the highest slot to slot 0, one cell per cycle; each cell
// it visits checks its own task and records the firing time. Firings (at most
// eight per tick) are collected and then delivered newest first, one per
// cycle while the result side takes them, the final one marked last; a tick
// with no firing delivers nothing. A tick first walks the token across the
// row and then delivers its results. New transactions are taken only while
// no tick is in progress and the result register is free or being emptied.
module periodic_task_dispatcher (
  input  logic      clk,
  input  logic      rst,
  ptd_in_if.sink    task_in,
  ptd_out_if.source result_out
);

  localparam int N = ptd_pkg::MAX_TASKS;

  ptd_pkg::state_t                          state;
  ptd_pkg::state_t                          state_next;
  logic [ptd_pkg::CNT_W-1:0]                task_count;
  logic [ptd_pkg::CNT_W-1:0]                task_count_next;
  logic [ptd_pkg::IDX_W-1:0]                walk_idx;
  logic [ptd_pkg::IDX_W-1:0]                walk_idx_next;
  logic [ptd_pkg::MASK_W-1:0]               tick_mask;
  logic [ptd_pkg::RES_CNT_W-1:0]            fire_count;
  logic [ptd_pkg::RES_CNT_W-1:0]            fire_count_next;
  logic [ptd_pkg::RES_IDX_W-1:0]            emit_ptr;
  logic [ptd_pkg::RES_IDX_W-1:0]            emit_ptr_next;
  logic [ptd_pkg::TASK_INDEX_W-1:0]         res_buf [ptd_pkg::RESULT_LIMIT];
  logic                                     buf_we;

  logic                                     out_valid;
  logic [ptd_pkg::STATUS_W-1:0]             out_status;
  logic [ptd_pkg::TASK_INDEX_W-1:0]         out_index;
  logic                                     out_last;
  logic                                     out_load;
  logic [ptd_pkg::STATUS_W-1:0]             out_status_next;
  logic [ptd_pkg::TASK_INDEX_W-1:0]         out_index_next;
  logic                                     out_last_next;
  logic                                     out_free;
  logic                                     in_accept;
  logic                                     table_full;
  logic                                     emit_last;
  logic                                     any_fire;

  ptd_pkg::tick_token_t                     inject;
  ptd_pkg::tick_token_t                     tok_in  [N];
  ptd_pkg::tick_token_t                     tok_out [N];
  ptd_pkg::task_write_t                     wr_data;
  logic [N-1:0]                             wr_en;
  logic [N-1:0]                             active;
  logic [N-1:0]                             enable;
  logic [N-1:0]                             fire_vec;

  assign out_free   = !out_valid || result_out.ready;
  assign task_in.ready = (state == ptd_pkg::S_IDLE) && out_free;
  assign in_accept  = task_in.valid && task_in.ready;
  assign table_full = (task_count == ptd_pkg::CNT_W'(N));
  assign any_fire   = |fire_vec;
  assign emit_last  = (ptd_pkg::RES_CNT_W'(emit_ptr) + ptd_pkg::RES_CNT_W'(1)) == fire_count;

  // Build the task entry for an add
  always_comb begin
    wr_data.kind     = task_in.task_kind;
    wr_data.interval = task_in.period_ms;
    wr_data.pending  = (task_in.task_kind == ptd_pkg::KIND_WORKER) &&
                       (task_in.start_delay_ms != '0);
    wr_data.start_at = wr_data.pending ? (task_in.now_ms + task_in.start_delay_ms) : '0;
  end

  // Row of task cells, token enters at the highest slot
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == N - 1) begin : g_head
      assign tok_in[g] = inject;
    end else begin : g_link
      assign tok_in[g] = tok_out[g + 1];
    end
    if (g < ptd_pkg::MASK_W) begin : g_en
      assign enable[g] = tick_mask[g];
    end else begin : g_no_en
      assign enable[g] = 1'b0;
    end
    assign active[g] = ptd_pkg::CNT_W'(g) < task_count;

    ptd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .token_in  (tok_in[g]),
      .token_out (tok_out[g]),
      .active    (active[g]),
      .enable    (enable[g]),
      .wr_en     (wr_en[g]),
      .wr_data   (wr_data),
      .fire      (fire_vec[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptd_pkg::S_IDLE;
      task_count <= '0;
      fire_count <= '0;
      emit_ptr   <= '0;
      walk_idx   <= '0;
    end else begin
      state      <= state_next;
      task_count <= task_count_next;
      fire_count <= fire_count_next;
      emit_ptr   <= emit_ptr_next;
      walk_idx   <= walk_idx_next;
    end
  end

  // Latch the enable mask of an accepted tick
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_mask <= task_in.enable_mask;
    end
  end

  // Collect fired indices during the walk
  always_ff @(posedge clk) begin
    if (buf_we) begin
      res_buf[fire_count[ptd_pkg::RES_IDX_W-1:0]] <= ptd_pkg::TASK_INDEX_W'(walk_idx);
    end
  end

  // Next state and result selection
  always_comb begin
    state_next      = state;
    task_count_next = task_count;
    walk_idx_next   = walk_idx;
    fire_count_next = fire_count;
    emit_ptr_next   = emit_ptr;
    buf_we          = 1'b0;
    wr_en           = '0;
    inject.valid    = 1'b0;
    inject.now      = task_in.now_ms;
    out_load        = 1'b0;
    out_status_next = out_status;
    out_index_next  = out_index;
    out_last_next   = out_last;

    unique case (state)
      ptd_pkg::S_IDLE: begin
        if (in_accept) begin
          if (task_in.action == ptd_pkg::ACTION_ADD) begin
            out_load      = 1'b1;
            out_last_next = 1'b1;
            if (table_full) begin
              out_status_next = ptd_pkg::STATUS_FULL;
              out_index_next  = '0;
            end else begin
              out_status_next = ptd_pkg::STATUS_ADDED;
              out_index_next  = ptd_pkg::TASK_INDEX_W'(task_count);
              wr_en[task_count[ptd_pkg::IDX_W-1:0]] = 1'b1;
              task_count_next = task_count + ptd_pkg::CNT_W'(1);
            end
          end else begin
            inject.valid    = 1'b1;
            walk_idx_next   = ptd_pkg::IDX_W'(N - 1);
            fire_count_next = '0;
            state_next      = ptd_pkg::S_WALK;
          end
        end
      end

      ptd_pkg::S_WALK: begin
        if (any_fire && (fire_count < ptd_pkg::RES_CNT_W'(ptd_pkg::RESULT_LIMIT))) begin
          buf_we          = 1'b1;
          fire_count_next = fire_count + ptd_pkg::RES_CNT_W'(1);
        end
        walk_idx_next = walk_idx - ptd_pkg::IDX_W'(1);
        // token sits in slot 0: walk ends
        if (tok_out[0].valid) begin
          emit_ptr_next = '0;
          state_next    = (fire_count_next != '0) ? ptd_pkg::S_EMIT : ptd_pkg::S_IDLE;
        end
      end

      ptd_pkg::S_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_status_next = ptd_pkg::STATUS_FIRED;
          out_index_next  = res_buf[emit_ptr];
          out_last_next   = emit_last;
          emit_ptr_next   = emit_ptr + ptd_pkg::RES_IDX_W'(1);
          if (emit_last) begin
            state_next = ptd_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_next = ptd_pkg::S_IDLE;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= out_status_next;
      out_index  <= out_index_next;
      out_last   <= out_last_next;
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.status     = out_status;
  assign result_out.task_index = out_index;
  assign result_out.last       = out_last;

endmodule

// ===== rtl/ptd_checker.sv =====
`include "periodic_task_dispatcher_macros.svh"

module ptd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_action,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ptd_pkg::STATUS_W-1:0]      out_status,
  input logic [ptd_pkg::TASK_INDEX_W-1:0]  out_index,
  input logic                              out_last
);

  logic in_txn;
  logic out_stall;

  assign in_txn    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // An add answers in the next cycle with a single final result
  `PTD_ASSERT_NEXT(a_add_answer, in_txn && (in_action == ptd_pkg::ACTION_ADD), out_valid && out_last && (out_status != ptd_pkg::STATUS_FIRED))

  // A tick holds off new transactions while the row is walked
  `PTD_ASSERT_NEXT(a_tick_busy, in_txn && (in_action == ptd_pkg::ACTION_TICK), !in_ready)

  // Add and full answers are always the final result of their transaction
  `PTD_ASSERT_SAME(a_add_last, out_valid && (out_status != ptd_pkg::STATUS_FIRED), out_last)

  // A stalled result holds its payload
  `PTD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_status) && $stable(out_index) && $stable(out_last))

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (task_in.valid),
  .in_ready   (task_in.ready),
  .in_action  (task_in.action),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .out_status (result_out.status),
  .out_index  (result_out.task_index),
  .out_last   (result_out.last)
);
